>>> rtl/core/dwvr_pkg.sv
`timescale 1ns / 1ps
package dwvr_pkg;

   // Command codes on req_func
   localparam logic [2:0] FN_CLEAR      = 3'd0;
   localparam logic [2:0] FN_PUSH_FRONT = 3'd1;
   localparam logic [2:0] FN_PUSH_BACK  = 3'd2;
   localparam logic [2:0] FN_POP_FRONT  = 3'd3;
   localparam logic [2:0] FN_POP_BACK   = 3'd4;
   localparam logic [2:0] FN_REMOVE     = 3'd5;

   // Status codes on rsp_status
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam int unsigned VALUE_W = 32;

   // What a cell does on the next edge
   typedef enum logic [1:0] {
      ACT_HOLD,
      ACT_LOAD,
      ACT_LEFT,
      ACT_RIGHT
   } act_type;

   typedef struct packed {
      act_type                    act;
      logic signed [VALUE_W-1:0]  operand;
   } cell_ctl_type;

endpackage

>>> rtl/core/dwvr_cell.sv
`timescale 1ns / 1ps
module dwvr_cell (
   input  logic                                     clock,
   input  dwvr_pkg::cell_ctl_type                   ctl,
   input  logic signed [dwvr_pkg::VALUE_W-1:0]      left_value,
   input  logic signed [dwvr_pkg::VALUE_W-1:0]      right_value,
   output logic signed [dwvr_pkg::VALUE_W-1:0]      value,
   output logic                                     match
);
   import dwvr_pkg::*;

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   always_comb begin
      case (ctl.act)
         ACT_LOAD:  value_in = ctl.operand;
         ACT_LEFT:  value_in = left_value;
         ACT_RIGHT: value_in = right_value;
         default:   value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign match = (value_ff == ctl.operand);

endmodule

>>> rtl/core/deque_with_value_removal_top.sv
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 32-bit values, front at cell 0, built as a
// row of CAPACITY cells that each hold one entry and shift it to a neighbor.
// Issue a command by raising start with req_func and req_operand_value while
// busy is low; the beat is taken on that edge. Busy then stays high for one
// cycle while every cell compares against the operand at once and the row
// shifts. The result beat appears on rsp_status / rsp_count_after for
// exactly one cycle with rsp_valid high, in the cycle right after the busy
// cycle; it cannot be held off, so capture it then. A new command may be
// issued in that same cycle. Status: done, empty or value not found, or
// full (push refused). Reset clears the entry count and the execute and
// result flags; cell contents are never read above the count.
module deque_with_value_removal_top #(
   parameter int unsigned CAPACITY = 64,
   localparam int unsigned CNT_W   = $clog2(CAPACITY + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [2:0]                            req_func,
   input  logic signed [dwvr_pkg::VALUE_W-1:0]   req_operand_value,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_status,
   output logic [CNT_W-1:0]                      rsp_count_after
);
   import dwvr_pkg::*;

   // command register, held for the execute cycle
   logic                      exec_ff, exec_in;
   logic [2:0]                func_ff;
   logic signed [VALUE_W-1:0] operand_ff;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      rsp_valid_ff;
   logic [1:0]                rsp_status_ff, status_in;
   logic [CNT_W-1:0]          rsp_count_ff;

   // cell row
   cell_ctl_type              ctl [CAPACITY];
   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]       cell_eq;

   // search over the occupied cells
   logic [CAPACITY-1:0]       occupied;
   logic [CAPACITY-1:0]       hit;
   logic [CAPACITY-1:0]       below_first;
   logic                      found;
   logic                      is_full, is_empty;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic signed [VALUE_W-1:0] left_v, right_v;
         // cell 0 takes the operand on a front push; the last cell has no
         // right neighbor and never shifts left into a live slot
         if (g == 0) begin : g_first
            assign left_v = operand_ff;
         end else begin : g_mid_l
            assign left_v = cell_value[g-1];
         end
         if (g == CAPACITY - 1) begin : g_last
            assign right_v = cell_value[g];
         end else begin : g_mid_r
            assign right_v = cell_value[g+1];
         end

         dwvr_cell u_cell (
            .clock       (clock),
            .ctl         (ctl[g]),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_value[g]),
            .match       (cell_eq[g])
         );
      end
   endgenerate

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         occupied[i] = (count_ff > CNT_W'(i));
      end
   end

   // Isolate everything below the first hit with one wide subtract:
   // cells at or above the first hit take their right neighbor's value on a removal.
   assign hit         = cell_eq & occupied;
   assign below_first = ~hit & (hit - CAPACITY'(1));
   assign found       = |hit;
   assign is_full     = (count_ff == CNT_W'(CAPACITY));
   assign is_empty    = (count_ff == '0);

   // Per-cell actions, next count and status for the execute cycle
   always_comb begin
      status_in = ST_DONE;
      count_in  = count_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         ctl[i].act     = ACT_HOLD;
         ctl[i].operand = operand_ff;
      end
      if (exec_ff) begin
         unique case (func_ff)
            FN_CLEAR: begin
               count_in = '0;
            end
            FN_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  for (int i = 0; i < CAPACITY; i++) begin
                     ctl[i].act = ACT_LEFT;
                  end
                  count_in = count_ff + CNT_W'(1);
               end
            end
            FN_PUSH_BACK: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  for (int i = 0; i < CAPACITY; i++) begin
                     if (count_ff == CNT_W'(i)) begin
                        ctl[i].act = ACT_LOAD;
                     end
                  end
                  count_in = count_ff + CNT_W'(1);
               end
            end
            FN_POP_FRONT: begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  for (int i = 0; i < CAPACITY; i++) begin
                     ctl[i].act = ACT_RIGHT;
                  end
                  count_in = count_ff - CNT_W'(1);
               end
            end
            FN_POP_BACK: begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            FN_REMOVE: begin
               if (!found) begin
                  status_in = ST_EMPTY;
               end else begin
                  // close the gap: the hit cell and all behind it advance
                  for (int i = 0; i < CAPACITY; i++) begin
                     if (!below_first[i]) begin
                        ctl[i].act = ACT_RIGHT;
                     end
                  end
                  count_in = count_ff - CNT_W'(1);
               end
            end
            default: begin
               // unused codes: drop, report done
            end
         endcase
      end
   end

   assign exec_in = start && !exec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exec_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         exec_ff      <= exec_in;
         count_ff     <= count_in;
         rsp_valid_ff <= exec_ff;
      end
   end

   // capture the command beat; hold it through the execute cycle
   always_ff @(posedge clock) begin
      if (exec_in) begin
         func_ff    <= req_func;
         operand_ff <= req_operand_value;
      end
      if (exec_ff) begin
         rsp_status_ff <= status_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign busy            = exec_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_count_after = rsp_count_ff;

   // Execute lasts exactly one cycle
   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      exec_ff |=> !exec_ff)
      else $error("execute cycle longer than one clock");

   // Every execute cycle yields one result beat next cycle, and only then
   a_rsp_follows_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff == $past(exec_ff))
      else $error("result beat not tied to execute cycle");

   // Count never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // Count moves by at most one per command other than a clear
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      exec_ff && func_ff != FN_CLEAR |=>
         (count_ff == $past(count_ff)) ||
         (count_ff == $past(count_ff) + CNT_W'(1)) ||
         (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("entry count jumped");

   // A refused push leaves the count at capacity
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      exec_ff && status_in == ST_FULL |=> count_ff == CNT_W'(CAPACITY))
      else $error("full push changed the count");

endmodule

>>> sim/tb_deque_with_value_removal_top.sv
`timescale 1ns / 1ps
module tb_deque_with_value_removal_top;
   import dwvr_pkg::*;

   localparam int unsigned DEPTH       = 64;
   localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
   // Codes outside the command set; the block must ignore them
   localparam logic [2:0]  FN_UNUSED_6 = 3'd6;
   localparam logic [2:0]  FN_UNUSED_7 = 3'd7;
   // Window of accepted beats with the sender never idling
   localparam int          BURST_LO    = 400;
   localparam int          BURST_HI    = 650;

   typedef struct {
      logic [2:0]                  func;
      logic signed [VALUE_W-1:0]   operand;
   } cmd_type;

   typedef struct {
      logic [1:0]       status;
      logic [CNT_W-1:0] count;
   } reply_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic [2:0]                  req_func = FN_CLEAR;
   logic signed [VALUE_W-1:0]   req_operand_value = '0;
   logic                        busy;
   logic                        rsp_valid;
   logic [1:0]                  rsp_status;
   logic [CNT_W-1:0]            rsp_count_after;

   // Commands waiting to be issued, expected replies in issue order,
   // and the shadow copy of the deque contents (index 0 is the front)
   cmd_type                     cmd_backlog[$];
   reply_type                   expected_replies[$];
   logic signed [VALUE_W-1:0]   shadow_deque[$];
   logic signed [VALUE_W-1:0]   value_pool[8];

   int                          issued = 0;
   int                          generated = 0;
   int                          mismatches = 0;

   deque_with_value_removal_top #(
      .CAPACITY(DEPTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_count_after   (rsp_count_after)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one command to the shadow deque and return the reply it should give
   function automatic reply_type apply_to_shadow(cmd_type c);
      reply_type r;
      int        hit;
      r.status = ST_DONE;
      hit      = -1;
      case (c.func)
         FN_CLEAR: shadow_deque.delete();
         FN_PUSH_FRONT: begin
            if (shadow_deque.size() >= DEPTH) r.status = ST_FULL;
            else shadow_deque.push_front(c.operand);
         end
         FN_PUSH_BACK: begin
            if (shadow_deque.size() >= DEPTH) r.status = ST_FULL;
            else shadow_deque.push_back(c.operand);
         end
         FN_POP_FRONT: begin
            if (shadow_deque.size() == 0) r.status = ST_EMPTY;
            else void'(shadow_deque.pop_front());
         end
         FN_POP_BACK: begin
            if (shadow_deque.size() == 0) r.status = ST_EMPTY;
            else void'(shadow_deque.pop_back());
         end
         FN_REMOVE: begin
            // search from the front so only the nearest duplicate goes
            for (int i = 0; i < shadow_deque.size() && hit < 0; i++)
               if (shadow_deque[i] == c.operand) hit = i;
            if (hit < 0) r.status = ST_EMPTY;
            else shadow_deque.delete(hit);
         end
         default: ;
      endcase
      r.count = CNT_W'(shadow_deque.size());
      return r;
   endfunction

   // Mostly draw from a small pool so removals hit and duplicates build up
   function automatic logic signed [VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 3) != 0) return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   function automatic logic [2:0] pick_push();
      return $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
   endfunction

   function automatic logic [2:0] pick_pop();
      return $urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK;
   endfunction

   task automatic enqueue(logic [2:0] func, logic signed [VALUE_W-1:0] operand);
      cmd_type c;
      c.func    = func;
      c.operand = operand;
      cmd_backlog.push_back(c);
      generated++;
   endtask

   // Driver: capture the beat taken on this edge, then hold, advance or idle
   always @(posedge clock) begin
      cmd_type   nxt;
      cmd_type   taken;
      reply_type want;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            taken.func    = req_func;
            taken.operand = req_operand_value;
            want          = apply_to_shadow(taken);
            expected_replies.push_back(want);
            issued++;
         end
         // While busy is high with start up, hold the beat unchanged
         if (!start || !busy) begin
            if (cmd_backlog.size() != 0 &&
                !($urandom_range(0, 99) < 20 && !(issued >= BURST_LO && issued < BURST_HI))) begin
               nxt                = cmd_backlog.pop_front();
               start             <= 1'b1;
               req_func          <= nxt.func;
               req_operand_value <= nxt.operand;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: a reply strobe lasts one cycle, so check it on the edge that ends it
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected reply beat: status %0d count %0d",
                        rsp_status, rsp_count_after);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_status !== want.status || rsp_count_after !== want.count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("reply mismatch: status exp %0d got %0d, count exp %0d got %0d",
                           want.status, rsp_status, want.count, rsp_count_after);
            end
         end
      end
   end

   initial begin
      int sel;
      int pick;

      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7FFF_FFFF;
      value_pool[2] = '0;
      value_pool[3] = -1;
      for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

      // Directed: empty-queue refusals, extreme values, duplicates,
      // absent removal, unused codes, then both pops, more removals and pushes, and a clear
      enqueue(FN_CLEAR,      $urandom);
      enqueue(FN_POP_FRONT,  $urandom);
      enqueue(FN_POP_BACK,   $urandom);
      enqueue(FN_REMOVE,     32'sd5);
      enqueue(FN_PUSH_FRONT, 32'sh8000_0000);
      enqueue(FN_PUSH_BACK,  32'sh7FFF_FFFF);
      enqueue(FN_PUSH_FRONT, -1);
      enqueue(FN_PUSH_BACK,  '0);
      enqueue(FN_PUSH_BACK,  -1);
      enqueue(FN_PUSH_FRONT, 32'sd7);
      enqueue(FN_REMOVE,     -1);
      enqueue(FN_REMOVE,     32'sd12345);
      enqueue(FN_UNUSED_6,   $urandom);
      enqueue(FN_UNUSED_7,   $urandom);
      enqueue(FN_POP_FRONT,  $urandom);
      enqueue(FN_POP_BACK,   $urandom);
      enqueue(FN_REMOVE,     32'sh7FFF_FFFF);
      enqueue(FN_REMOVE,     32'sh8000_0000);
      enqueue(FN_PUSH_FRONT, 32'sh5555_5555);
      enqueue(FN_PUSH_BACK,  32'shAAAA_AAAA);
      enqueue(FN_REMOVE,     -1);
      enqueue(FN_CLEAR,      $urandom);

      // Random: mostly single commands, with fill-past-full and
      // drain-past-empty runs mixed in so both limits are hit often
      while (generated < 1000) begin
         sel = $urandom_range(0, 19);
         if (sel == 0) begin
            enqueue(FN_CLEAR, $urandom);
            repeat (DEPTH + $urandom_range(1, 4)) enqueue(pick_push(), pick_value());
            repeat ($urandom_range(2, 8)) enqueue(FN_REMOVE, pick_value());
         end else if (sel == 1) begin
            repeat ($urandom_range(5, 70)) enqueue(pick_pop(), $urandom);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 3)       enqueue(FN_CLEAR, $urandom);
            else if (pick < 6)  enqueue($urandom_range(0, 1) ? FN_UNUSED_6 : FN_UNUSED_7,
                                        $urandom);
            else if (pick < 40) enqueue(pick_push(), pick_value());
            else if (pick < 60) enqueue(pick_pop(), $urandom);
            else                enqueue(FN_REMOVE, pick_value());
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Drain: every beat taken and every reply seen, then a short tail
      while (cmd_backlog.size() != 0 || start || expected_replies.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);

      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
